// File: rtl/c3fm_pkg.sv
// Shared types and constants of the 3x3 first-moment centroid core.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package c3fm_pkg;

	localparam int INDEX_BITS  = 16;
	localparam int BG_BITS     = 24;
	localparam int POS_BITS    = 32;
	localparam int STATUS_BITS = 2;
	localparam int WINDOW      = 9;

	// Positions of the window pixels in the internal pixel array.
	localparam int PIX_UL = 0;
	localparam int PIX_UM = 1;
	localparam int PIX_UR = 2;
	localparam int PIX_ML = 3;
	localparam int PIX_C  = 4;
	localparam int PIX_MR = 5;
	localparam int PIX_DL = 6;
	localparam int PIX_DM = 7;
	localparam int PIX_DR = 8;

	typedef enum logic [STATUS_BITS-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_COUNTS = 2'd1,
		STATUS_SATURATED = 2'd2
	} status_t;

	// Per-request information that rides along with the divider pipeline.
	typedef struct packed {
		logic [INDEX_BITS-1:0] col;
		logic [INDEX_BITS-1:0] row;
		logic                  neg_col;
		logic                  neg_row;
		logic                  no_counts;
	} side_t;

endpackage

// File: rtl/c3fm_if.sv
// Valid/ready channel interfaces for the window requests and the centroid results.
// Depends on c3fm_pkg for the index and position widths.
`timescale 1ns / 1ps

interface c3fm_in_if #(
	parameter int PIXEL_BITS = 24
);
	logic                                 valid;
	logic                                 ready;
	logic signed [PIXEL_BITS-1:0]         pix_up_left;
	logic signed [PIXEL_BITS-1:0]         pix_up_mid;
	logic signed [PIXEL_BITS-1:0]         pix_up_right;
	logic signed [PIXEL_BITS-1:0]         pix_mid_left;
	logic signed [PIXEL_BITS-1:0]         pix_center;
	logic signed [PIXEL_BITS-1:0]         pix_mid_right;
	logic signed [PIXEL_BITS-1:0]         pix_down_left;
	logic signed [PIXEL_BITS-1:0]         pix_down_mid;
	logic signed [PIXEL_BITS-1:0]         pix_down_right;
	logic [c3fm_pkg::INDEX_BITS-1:0]      col_index;
	logic [c3fm_pkg::INDEX_BITS-1:0]      row_index;

	modport source (
		output valid, pix_up_left, pix_up_mid, pix_up_right, pix_mid_left, pix_center,
		       pix_mid_right, pix_down_left, pix_down_mid, pix_down_right,
		       col_index, row_index,
		input  ready
	);
	modport sink (
		input  valid, pix_up_left, pix_up_mid, pix_up_right, pix_mid_left, pix_center,
		       pix_mid_right, pix_down_left, pix_down_mid, pix_down_right,
		       col_index, row_index,
		output ready
	);
endinterface

interface c3fm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [c3fm_pkg::POS_BITS-1:0] centroid_col;
	logic signed [c3fm_pkg::POS_BITS-1:0] centroid_row;
	logic [c3fm_pkg::STATUS_BITS-1:0]     result_status;

	modport source (
		output valid, centroid_col, centroid_row, result_status,
		input  ready
	);
	modport sink (
		input  valid, centroid_col, centroid_row, result_status,
		output ready
	);
endinterface

// File: rtl/centroid_3x3_first_moment_core.sv
// Top level of the 3x3 first-moment centroid core: input skid register,
// background register, moment front end, pipelined divider and output stage.
// Depends on c3fm_pkg, c3fm_if, c3fm_moments, c3fm_divider and c3fm_finish.
`timescale 1ns / 1ps

//  channel   | direction | handshake    | payload
//  ----------+-----------+--------------+-------------------------------------------
//  pix_in    | in        | valid/ready  | nine window pixels, col_index, row_index
//  res_out   | out       | valid/ready  | centroid_col, centroid_row, result_status
//  cfg       | in        | cfg_wr_en    | cfg_wr_data: background level per pixel
//
//  One request enters per clock while the pipeline is not held. Its result passes the
//  moment front end and the divider into the output register, which drives res_out.
//  The divider resolves one quotient bit per pipeline stage; its dividend is NUM_BITS =
//  max(PIXEL_BITS + 2 + FRACTION_BITS, max(PIXEL_BITS, 24) + 3) + 1 bits wide.
//  Reset clears all valid bits and the background level; no clearing pass.
//  When the result is not taken the whole pipeline holds, and one more
//  request is caught in the input skid register.

module centroid_3x3_first_moment_core #(
	parameter int PIXEL_BITS    = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [c3fm_pkg::BG_BITS-1:0]        cfg_wr_data,
	c3fm_in_if.sink                             pix_in,
	c3fm_out_if.source                          res_out
);

	// Signed width of the window sum less background; its magnitude is the divisor.
	localparam int SUM_BITS = ((PIXEL_BITS > c3fm_pkg::BG_BITS) ? PIXEL_BITS
	                                                             : c3fm_pkg::BG_BITS) + 5;
	localparam int DEN_BITS = SUM_BITS - 1;
	// Dividend: scaled moment magnitude plus half the divisor, with a carry bit.
	localparam int SCALED   = PIXEL_BITS + 2 + FRACTION_BITS;
	localparam int NUM_BITS = ((SCALED > DEN_BITS - 1) ? SCALED : DEN_BITS - 1) + 1;

	// Plain background register; write it only while idle (not enforced).
	logic signed [c3fm_pkg::BG_BITS-1:0] bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= '0;
		end else if (cfg_wr_en) begin
			bg_q <= cfg_wr_data;
		end
	end

	// Every stage advances together whenever the output register is empty or
	// being drained.
	logic en;
	logic fin_valid;
	assign en = !fin_valid || res_out.ready;

	// Input skid register: a request that arrives while the pipeline holds is
	// parked here, and ready drops until it has moved on.
	logic                            skid_valid_q;
	logic signed [PIXEL_BITS-1:0]    skid_pix_q [c3fm_pkg::WINDOW];
	logic [c3fm_pkg::INDEX_BITS-1:0] skid_col_q, skid_row_q;
	logic signed [PIXEL_BITS-1:0]    in_pix [c3fm_pkg::WINDOW];
	logic signed [PIXEL_BITS-1:0]    sel_pix [c3fm_pkg::WINDOW];
	logic [c3fm_pkg::INDEX_BITS-1:0] sel_col, sel_row;
	logic                            take;
	logic                            front_valid;

	assign pix_in.ready = !skid_valid_q;
	assign take         = pix_in.valid && pix_in.ready;
	assign front_valid  = skid_valid_q || take;

	always_comb begin
		in_pix[c3fm_pkg::PIX_UL] = pix_in.pix_up_left;
		in_pix[c3fm_pkg::PIX_UM] = pix_in.pix_up_mid;
		in_pix[c3fm_pkg::PIX_UR] = pix_in.pix_up_right;
		in_pix[c3fm_pkg::PIX_ML] = pix_in.pix_mid_left;
		in_pix[c3fm_pkg::PIX_C]  = pix_in.pix_center;
		in_pix[c3fm_pkg::PIX_MR] = pix_in.pix_mid_right;
		in_pix[c3fm_pkg::PIX_DL] = pix_in.pix_down_left;
		in_pix[c3fm_pkg::PIX_DM] = pix_in.pix_down_mid;
		in_pix[c3fm_pkg::PIX_DR] = pix_in.pix_down_right;
		for (int i = 0; i < c3fm_pkg::WINDOW; i++) begin
			sel_pix[i] = skid_valid_q ? skid_pix_q[i] : in_pix[i];
		end
		sel_col = skid_valid_q ? skid_col_q : pix_in.col_index;
		sel_row = skid_valid_q ? skid_row_q : pix_in.row_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else begin
			skid_valid_q <= en ? 1'b0 : (skid_valid_q || take);
		end
	end

	always_ff @(posedge clk) begin
		if (take && !en) begin
			for (int i = 0; i < c3fm_pkg::WINDOW; i++) begin
				skid_pix_q[i] <= in_pix[i];
			end
			skid_col_q <= pix_in.col_index;
			skid_row_q <= pix_in.row_index;
		end
	end

	// Moment front end: three stages.
	logic                mom_valid;
	logic [NUM_BITS-1:0] mom_num_col, mom_num_row;
	logic [DEN_BITS-1:0] mom_den;
	c3fm_pkg::side_t     mom_side;

	c3fm_moments #(
		.PIXEL_BITS    (PIXEL_BITS),
		.FRACTION_BITS (FRACTION_BITS),
		.SUM_BITS      (SUM_BITS),
		.NUM_BITS      (NUM_BITS)
	) u_moments (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.pix       (sel_pix),
		.bg        (bg_q),
		.col       (sel_col),
		.row       (sel_row),
		.out_valid (mom_valid),
		.num_col   (mom_num_col),
		.num_row   (mom_num_row),
		.den       (mom_den),
		.side      (mom_side)
	);

	// Divider: one stage per quotient bit, both offsets at once.
	logic                div_valid;
	logic [NUM_BITS-1:0] div_quo_col, div_quo_row;
	c3fm_pkg::side_t     div_side;

	c3fm_divider #(
		.NUM_BITS (NUM_BITS),
		.DEN_BITS (DEN_BITS)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mom_valid),
		.num_a     (mom_num_col),
		.num_b     (mom_num_row),
		.den       (mom_den),
		.side_in   (mom_side),
		.out_valid (div_valid),
		.quo_a     (div_quo_col),
		.quo_b     (div_quo_row),
		.side_out  (div_side)
	);

	// Output stage doubles as the result register seen on res_out.
	c3fm_pkg::status_t fin_status;

	c3fm_finish #(
		.NUM_BITS      (NUM_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.quo_col   (div_quo_col),
		.quo_row   (div_quo_row),
		.side      (div_side),
		.out_valid (fin_valid),
		.pos_col   (res_out.centroid_col),
		.pos_row   (res_out.centroid_row),
		.status    (fin_status)
	);

	assign res_out.valid         = fin_valid;
	assign res_out.result_status = fin_status;

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> $past(!en))
		else $error("skid register filled while the pipeline was advancing");

	a_no_counts_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.result_status == c3fm_pkg::STATUS_NO_COUNTS)
		|-> (res_out.centroid_col == '0 && res_out.centroid_row == '0))
		else $error("zero-sum result carries nonzero positions");

	a_saturated_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.result_status == c3fm_pkg::STATUS_SATURATED)
		|-> (res_out.centroid_col == 32'sh7fffffff || res_out.centroid_col == 32'sh80000000
		  || res_out.centroid_row == 32'sh7fffffff || res_out.centroid_row == 32'sh80000000))
		else $error("saturated status without a clamped position");

endmodule

// File: rtl/c3fm_moments.sv
// Three-stage front end: window sum less background, first moments, and the
// divider operands (magnitudes with the rounding half-divisor folded in). Uses c3fm_pkg.
`timescale 1ns / 1ps

module c3fm_moments #(
	parameter int PIXEL_BITS    = 24,
	parameter int FRACTION_BITS = 16,
	parameter int SUM_BITS      = 29,
	parameter int NUM_BITS      = 43
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [PIXEL_BITS-1:0]        pix [c3fm_pkg::WINDOW],
	input  logic signed [c3fm_pkg::BG_BITS-1:0] bg,
	input  logic [c3fm_pkg::INDEX_BITS-1:0]     col,
	input  logic [c3fm_pkg::INDEX_BITS-1:0]     row,
	output logic                                out_valid,
	output logic [NUM_BITS-1:0]                 num_col,
	output logic [NUM_BITS-1:0]                 num_row,
	output logic [SUM_BITS-2:0]                 den,
	output c3fm_pkg::side_t                     side
);

	localparam int DEN_BITS = SUM_BITS - 1;
	localparam int MAG_BITS = PIXEL_BITS + 2;

	logic signed [SUM_BITS-1:0] ext [c3fm_pkg::WINDOW];
	logic signed [SUM_BITS-1:0] bg_ext;

	// Stage 1: row sums, column sums and nine times the background.
	logic                            v_s1;
	logic signed [SUM_BITS-1:0]      r_up_s1, r_mid_s1, r_dn_s1, c_l_s1, c_r_s1, bg9_s1;
	logic [c3fm_pkg::INDEX_BITS-1:0] col_s1, row_s1;

	// Stage 2: signed sum and moments.
	logic                            v_s2;
	logic signed [SUM_BITS-1:0]      s_s2, mx_s2, my_s2;
	logic [c3fm_pkg::INDEX_BITS-1:0] col_s2, row_s2;

	// Stage 3: divider operands.
	logic                            v_s3;
	logic [NUM_BITS-1:0]             num_col_s3, num_row_s3;
	logic [DEN_BITS-1:0]             den_s3;
	c3fm_pkg::side_t                 side_s3;

	logic [SUM_BITS-1:0] s_abs, mx_abs, my_abs;

	always_comb begin
		for (int i = 0; i < c3fm_pkg::WINDOW; i++) begin
			ext[i] = {{(SUM_BITS-PIXEL_BITS){pix[i][PIXEL_BITS-1]}}, pix[i]};
		end
		bg_ext = {{(SUM_BITS-c3fm_pkg::BG_BITS){bg[c3fm_pkg::BG_BITS-1]}}, bg};
	end

	always_comb begin
		s_abs  = s_s2[SUM_BITS-1] ? -s_s2 : s_s2;
		mx_abs = mx_s2[SUM_BITS-1] ? -mx_s2 : mx_s2;
		my_abs = my_s2[SUM_BITS-1] ? -my_s2 : my_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_up_s1  <= ext[c3fm_pkg::PIX_UL] + ext[c3fm_pkg::PIX_UM] + ext[c3fm_pkg::PIX_UR];
			r_mid_s1 <= ext[c3fm_pkg::PIX_ML] + ext[c3fm_pkg::PIX_C] + ext[c3fm_pkg::PIX_MR];
			r_dn_s1  <= ext[c3fm_pkg::PIX_DL] + ext[c3fm_pkg::PIX_DM] + ext[c3fm_pkg::PIX_DR];
			c_l_s1   <= ext[c3fm_pkg::PIX_UL] + ext[c3fm_pkg::PIX_ML] + ext[c3fm_pkg::PIX_DL];
			c_r_s1   <= ext[c3fm_pkg::PIX_UR] + ext[c3fm_pkg::PIX_MR] + ext[c3fm_pkg::PIX_DR];
			bg9_s1   <= (bg_ext <<< 3) + bg_ext;
			col_s1   <= col;
			row_s1   <= row;

			s_s2   <= r_up_s1 + r_mid_s1 + r_dn_s1 - bg9_s1;
			mx_s2  <= c_r_s1 - c_l_s1;
			my_s2  <= r_up_s1 - r_dn_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;

			// Rounding to nearest, ties away from zero: add half the divisor
			// to the magnitude of the scaled moment before dividing.
			num_col_s3 <= (NUM_BITS'(mx_abs[MAG_BITS-1:0]) << FRACTION_BITS)
			              + NUM_BITS'(s_abs[DEN_BITS-1:1]);
			num_row_s3 <= (NUM_BITS'(my_abs[MAG_BITS-1:0]) << FRACTION_BITS)
			              + NUM_BITS'(s_abs[DEN_BITS-1:1]);
			den_s3             <= s_abs[DEN_BITS-1:0];
			side_s3.col        <= col_s2;
			side_s3.row        <= row_s2;
			side_s3.neg_col    <= mx_s2[SUM_BITS-1] ^ s_s2[SUM_BITS-1];
			side_s3.neg_row    <= my_s2[SUM_BITS-1] ^ s_s2[SUM_BITS-1];
			side_s3.no_counts  <= (s_s2 == '0);
		end
	end

	assign out_valid = v_s3;
	assign num_col   = num_col_s3;
	assign num_row   = num_row_s3;
	assign den       = den_s3;
	assign side      = side_s3;

endmodule

// File: rtl/c3fm_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two numerators over
// one shared divisor. Uses c3fm_pkg for the side information carried along.
`timescale 1ns / 1ps

module c3fm_divider #(
	parameter int NUM_BITS = 43,
	parameter int DEN_BITS = 28
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [NUM_BITS-1:0] num_a,
	input  logic [NUM_BITS-1:0] num_b,
	input  logic [DEN_BITS-1:0] den,
	input  c3fm_pkg::side_t     side_in,
	output logic                out_valid,
	output logic [NUM_BITS-1:0] quo_a,
	output logic [NUM_BITS-1:0] quo_b,
	output c3fm_pkg::side_t     side_out
);

	localparam int WORK_BITS = DEN_BITS + NUM_BITS;

	// Remainder in the upper part, numerator bits shifting out and quotient
	// bits shifting in at the lower part.
	function automatic logic [WORK_BITS-1:0] div_step(
		input logic [WORK_BITS-1:0] w,
		input logic [DEN_BITS-1:0]  d
	);
		logic [WORK_BITS:0]  sh;
		logic [DEN_BITS:0]   trial;
		logic [WORK_BITS-1:0] res;
		sh    = {w, 1'b0};
		trial = sh[WORK_BITS:NUM_BITS] - {1'b0, d};
		if (!trial[DEN_BITS]) begin
			res = {trial[DEN_BITS-1:0], sh[NUM_BITS-1:1], 1'b1};
		end else begin
			res = sh[WORK_BITS-1:0];
		end
		return res;
	endfunction

	logic                 v_s    [1:NUM_BITS];
	logic [WORK_BITS-1:0] work_a_s [1:NUM_BITS];
	logic [WORK_BITS-1:0] work_b_s [1:NUM_BITS];
	logic [DEN_BITS-1:0]  den_s  [1:NUM_BITS];
	c3fm_pkg::side_t      side_s [1:NUM_BITS];

	for (genvar k = 1; k <= NUM_BITS; k++) begin : g_stage
		logic                 prev_v;
		logic [WORK_BITS-1:0] prev_a, prev_b;
		logic [DEN_BITS-1:0]  prev_d;
		c3fm_pkg::side_t      prev_side;

		if (k == 1) begin : g_first
			assign prev_v    = in_valid;
			assign prev_a    = {{DEN_BITS{1'b0}}, num_a};
			assign prev_b    = {{DEN_BITS{1'b0}}, num_b};
			assign prev_d    = den;
			assign prev_side = side_in;
		end else begin : g_next
			assign prev_v    = v_s[k-1];
			assign prev_a    = work_a_s[k-1];
			assign prev_b    = work_b_s[k-1];
			assign prev_d    = den_s[k-1];
			assign prev_side = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				work_a_s[k] <= div_step(prev_a, prev_d);
				work_b_s[k] <= div_step(prev_b, prev_d);
				den_s[k]    <= prev_d;
				side_s[k]   <= prev_side;
			end
		end
	end

	assign out_valid = v_s[NUM_BITS];
	assign quo_a     = work_a_s[NUM_BITS][NUM_BITS-1:0];
	assign quo_b     = work_b_s[NUM_BITS][NUM_BITS-1:0];
	assign side_out  = side_s[NUM_BITS];

	logic [DEN_BITS-1:0] rem_a, rem_b;
	assign rem_a = work_a_s[NUM_BITS][WORK_BITS-1:NUM_BITS];
	assign rem_b = work_b_s[NUM_BITS][WORK_BITS-1:NUM_BITS];

	a_rem_a_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && den_s[NUM_BITS] != '0) |-> (rem_a < den_s[NUM_BITS]))
		else $error("divider lane a remainder not below divisor");

	a_rem_b_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && den_s[NUM_BITS] != '0) |-> (rem_b < den_s[NUM_BITS]))
		else $error("divider lane b remainder not below divisor");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(out_valid) && $stable(quo_a) && $stable(quo_b)))
		else $error("divider output moved while stalled");

endmodule

// File: rtl/c3fm_finish.sv
// Output stage: adds the signed offsets to the scaled indices, clamps to the
// 32-bit range and forms the status. Uses c3fm_pkg.
`timescale 1ns / 1ps

module c3fm_finish #(
	parameter int NUM_BITS      = 43,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic [NUM_BITS-1:0]                   quo_col,
	input  logic [NUM_BITS-1:0]                   quo_row,
	input  c3fm_pkg::side_t                       side,
	output logic                                  out_valid,
	output logic signed [c3fm_pkg::POS_BITS-1:0]  pos_col,
	output logic signed [c3fm_pkg::POS_BITS-1:0]  pos_row,
	output c3fm_pkg::status_t                     status
);

	localparam int IDX_SCALED = c3fm_pkg::INDEX_BITS + FRACTION_BITS;
	localparam int WIDE_A     = (NUM_BITS > IDX_SCALED) ? NUM_BITS : IDX_SCALED;
	localparam int WIDE_B     = (WIDE_A > c3fm_pkg::POS_BITS) ? WIDE_A : c3fm_pkg::POS_BITS;
	localparam int PW         = WIDE_B + 2;

	logic signed [PW-1:0] sum_col, sum_row;
	logic signed [c3fm_pkg::POS_BITS-1:0] clamp_col, clamp_row;
	logic sat_col, sat_row;

	function automatic logic signed [PW-1:0] place(
		input logic [c3fm_pkg::INDEX_BITS-1:0] idx,
		input logic [NUM_BITS-1:0]             q,
		input logic                            neg
	);
		logic signed [PW-1:0] base;
		logic signed [PW-1:0] off;
		base = PW'(idx) << FRACTION_BITS;
		off  = PW'(q);
		return neg ? (base - off) : (base + off);
	endfunction

	// A value fits in 32 signed bits when all bits from bit 31 upward agree.
	function automatic logic clamp32(
		input  logic signed [PW-1:0]                 v,
		output logic signed [c3fm_pkg::POS_BITS-1:0] r
	);
		logic [PW-c3fm_pkg::POS_BITS:0] top;
		logic                           fits;
		top  = v[PW-1:c3fm_pkg::POS_BITS-1];
		fits = (top == '0) || (top == '1);
		if (fits) begin
			r = v[c3fm_pkg::POS_BITS-1:0];
		end else if (v[PW-1]) begin
			r = {1'b1, {(c3fm_pkg::POS_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(c3fm_pkg::POS_BITS-1){1'b1}}};
		end
		return !fits;
	endfunction

	always_comb begin
		sum_col = place(side.col, quo_col, side.neg_col);
		sum_row = place(side.row, quo_row, side.neg_row);
		sat_col = clamp32(sum_col, clamp_col);
		sat_row = clamp32(sum_row, clamp_row);
	end

	logic                                 v_s1;
	logic signed [c3fm_pkg::POS_BITS-1:0] col_s1, row_s1;
	c3fm_pkg::status_t                    status_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side.no_counts) begin
				col_s1    <= '0;
				row_s1    <= '0;
				status_s1 <= c3fm_pkg::STATUS_NO_COUNTS;
			end else begin
				col_s1    <= clamp_col;
				row_s1    <= clamp_row;
				status_s1 <= (sat_col || sat_row) ? c3fm_pkg::STATUS_SATURATED
				                                  : c3fm_pkg::STATUS_OK;
			end
		end
	end

	assign out_valid = v_s1;
	assign pos_col   = col_s1;
	assign pos_row   = row_s1;
	assign status    = status_s1;

endmodule

// File: dv/tb_centroid_3x3_first_moment_core.sv
// Self-checking testbench for the 3x3 first-moment centroid core: directed windows, then
// random window streams under three idle patterns, each result checked against a predictor.
// Depends on c3fm_pkg, the c3fm_in_if / c3fm_out_if interfaces and the core RTL.
`timescale 1ns / 1ps

module tb_centroid_3x3_first_moment_core;

	localparam int PIXEL_BITS    = 24;
	localparam int FRACTION_BITS = 16;
	localparam int CLK_PERIOD    = 12;

	// Divider width as the core computes it, and a pipeline depth derived from it.
	localparam int NUM_BITS     = ((PIXEL_BITS + 2 + FRACTION_BITS) > (PIXEL_BITS + 3) ?
	                               (PIXEL_BITS + 2 + FRACTION_BITS) : (PIXEL_BITS + 3)) + 1;
	localparam int PIPE_LATENCY = 3 + NUM_BITS;

	// Generous ceiling on the whole run, far above the slowest legal run.
	localparam int TIMEOUT_CYCLES = 300000;

	localparam logic [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
	localparam logic [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

	// One request: nine window pixels, indexed by the PIX_* positions, plus the column and row index.
	typedef struct packed {
		logic [c3fm_pkg::WINDOW-1:0][PIXEL_BITS-1:0] pix;
		logic [c3fm_pkg::INDEX_BITS-1:0]             col;
		logic [c3fm_pkg::INDEX_BITS-1:0]             row;
	} window_t;

	// One centroid result as the core should return it.
	typedef struct packed {
		logic signed [c3fm_pkg::POS_BITS-1:0] col;
		logic signed [c3fm_pkg::POS_BITS-1:0] row;
		c3fm_pkg::status_t                    status;
	} centroid_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [c3fm_pkg::BG_BITS-1:0] cfg_wr_data;

	c3fm_in_if #(.PIXEL_BITS(PIXEL_BITS)) pix_in ();
	c3fm_out_if                           res_out ();

	centroid_3x3_first_moment_core #(
		.PIXEL_BITS   (PIXEL_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.pix_in     (pix_in),
		.res_out    (res_out)
	);

	// Our own copy of the background register, updated whenever we write the core's.
	logic signed [c3fm_pkg::BG_BITS-1:0] background_level;

	// Centroids predicted for accepted requests, oldest first.
	centroid_t pending_centroids [$];
	centroid_t want;

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;
	int requests_sent;
	int results_ok;
	int results_no_counts;
	int results_saturated;
	int background_writes;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// The result side drops ready at random; the chance is changed per phase.
	always @(posedge clk) begin
		res_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [PIXEL_BITS-1:0] px(input longint value);
		return value[PIXEL_BITS-1:0];
	endfunction

	// index * 2^F + round(m * 2^F / s), ties away from zero, before clamping.
	// The division is done on magnitudes so the rounding is symmetric around zero.
	function automatic longint shifted_position(input logic [c3fm_pkg::INDEX_BITS-1:0] idx,
	                                            input longint m, input longint s);
		longint unsigned num;
		longint unsigned den;
		longint unsigned quot;
		longint          off;
		num  = (m < 0) ? -m : m;
		num  = num << FRACTION_BITS;
		den  = (s < 0) ? -s : s;
		quot = (num + den / 2) / den;
		off  = ((m < 0) != (s < 0)) ? -longint'(quot) : longint'(quot);
		return (longint'(idx) << FRACTION_BITS) + off;
	endfunction

	function automatic logic signed [c3fm_pkg::POS_BITS-1:0] clamp_position(
		input longint pos, output bit clipped);
		clipped = 1'b1;
		if (pos > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (pos < -64'sd2147483648)
			return 32'sh8000_0000;
		clipped = 1'b0;
		return pos[c3fm_pkg::POS_BITS-1:0];
	endfunction

	function automatic centroid_t predict_centroid(input window_t w);
		centroid_t r;
		longint    p [c3fm_pkg::WINDOW];
		longint    s;
		longint    mx;
		longint    my;
		bit        clip_col;
		bit        clip_row;
		s = 0;
		for (int i = 0; i < c3fm_pkg::WINDOW; i++) begin
			p[i] = longint'($signed(w.pix[i]));
			s   += p[i];
		end
		s -= longint'(c3fm_pkg::WINDOW) * longint'(background_level);
		// Horizontal moment: right column minus left column.
		mx = (p[c3fm_pkg::PIX_UR] - p[c3fm_pkg::PIX_UL])
		   + (p[c3fm_pkg::PIX_MR] - p[c3fm_pkg::PIX_ML])
		   + (p[c3fm_pkg::PIX_DR] - p[c3fm_pkg::PIX_DL]);
		// Vertical moment: upper row minus lower row.
		my = (p[c3fm_pkg::PIX_UL] + p[c3fm_pkg::PIX_UM] + p[c3fm_pkg::PIX_UR])
		   - (p[c3fm_pkg::PIX_DL] + p[c3fm_pkg::PIX_DM] + p[c3fm_pkg::PIX_DR]);
		r.col    = '0;
		r.row    = '0;
		r.status = c3fm_pkg::STATUS_OK;
		if (s == 0) begin
			// No counts wins over everything, even over an index that would saturate.
			r.status = c3fm_pkg::STATUS_NO_COUNTS;
		end else begin
			r.col = clamp_position(shifted_position(w.col, mx, s), clip_col);
			r.row = clamp_position(shifted_position(w.row, my, s), clip_row);
			if (clip_col || clip_row)
				r.status = c3fm_pkg::STATUS_SATURATED;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string field, input longint expv, input longint actv);
		mismatch_count++;
		$error("%s mismatch: expected %0d, actual %0d", field, expv, actv);
	endtask

	// Every accepted result is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && res_out.valid && res_out.ready) begin
			if (pending_centroids.size() == 0) begin
				report_mismatch("result_count", 0, 1);
			end else begin
				want = pending_centroids.pop_front();
				if (res_out.centroid_col !== want.col)
					report_mismatch("centroid_col", want.col, res_out.centroid_col);
				if (res_out.centroid_row !== want.row)
					report_mismatch("centroid_row", want.row, res_out.centroid_row);
				if (res_out.result_status !== want.status)
					report_mismatch("result_status", want.status, res_out.result_status);
				case (want.status)
					c3fm_pkg::STATUS_NO_COUNTS: results_no_counts++;
					c3fm_pkg::STATUS_SATURATED: results_saturated++;
					default:                    results_ok++;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Request driving and configuration
	// ------------------------------------------------------------------

	// Presents one request, sometimes after a random gap, and returns after the edge that
	// accepts it, once ready is high again. The prediction is queued when it returns.
	task automatic send_window(input window_t w);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		pix_in.valid          <= 1'b1;
		pix_in.pix_up_left    <= w.pix[c3fm_pkg::PIX_UL];
		pix_in.pix_up_mid     <= w.pix[c3fm_pkg::PIX_UM];
		pix_in.pix_up_right   <= w.pix[c3fm_pkg::PIX_UR];
		pix_in.pix_mid_left   <= w.pix[c3fm_pkg::PIX_ML];
		pix_in.pix_center     <= w.pix[c3fm_pkg::PIX_C];
		pix_in.pix_mid_right  <= w.pix[c3fm_pkg::PIX_MR];
		pix_in.pix_down_left  <= w.pix[c3fm_pkg::PIX_DL];
		pix_in.pix_down_mid   <= w.pix[c3fm_pkg::PIX_DM];
		pix_in.pix_down_right <= w.pix[c3fm_pkg::PIX_DR];
		pix_in.col_index      <= w.col;
		pix_in.row_index      <= w.row;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		pending_centroids.push_back(predict_centroid(w));
		requests_sent++;
	endtask

	task automatic wait_for_results();
		pix_in.valid <= 1'b0;
		while (pending_centroids.size() != 0)
			@(posedge clk);
	endtask

	// The background register is only written with the pipeline empty.
	task automatic write_background(input logic signed [c3fm_pkg::BG_BITS-1:0] level);
		wait_for_results();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= level;
		@(posedge clk);
		cfg_wr_en        <= 1'b0;
		background_level  = level;
		background_writes++;
	endtask

	function automatic window_t blank_window(input logic [c3fm_pkg::INDEX_BITS-1:0] col,
	                                         input logic [c3fm_pkg::INDEX_BITS-1:0] row);
		window_t w;
		w.pix = '0;
		w.col = col;
		w.row = row;
		return w;
	endfunction

	function automatic logic [c3fm_pkg::INDEX_BITS-1:0] random_index();
		int unsigned bits;
		bits = $urandom;
		// Mostly indices that can hold a valid position; some anywhere in range.
		if ($urandom_range(0, 9) == 0)
			return bits[c3fm_pkg::INDEX_BITS-1:0];
		bits = $urandom_range(0, 32767);
		return bits[c3fm_pkg::INDEX_BITS-1:0];
	endfunction

	// Random window. Nearly half are star-like spots over the background; some are pure noise,
	// some are balanced so the net sum is zero or within a few counts of it.
	function automatic window_t random_window();
		window_t     w;
		longint      p [c3fm_pkg::WINDOW];
		longint      base;
		longint      spread;
		longint      total;
		int          kind;
		int          spot;
		int unsigned bits;
		kind   = $urandom_range(0, 99);
		base   = longint'(background_level);
		spread = longint'(1) << $urandom_range(0, 20);
		w.col  = random_index();
		w.row  = random_index();
		total  = 0;
		for (int i = 0; i < c3fm_pkg::WINDOW; i++) begin
			if (kind < 30) begin
				bits = $urandom;
				p[i] = longint'(bits);
			end else if (kind < 70 || kind >= 92) begin
				p[i] = base + longint'($urandom_range(0, 32'(spread)));
			end else begin
				p[i] = base + longint'($urandom_range(0, 32'(2 * spread))) - spread;
			end
			total += p[i];
		end
		if (kind >= 70 && kind < 92) begin
			// Rebalance one pixel so the sum lands on zero, or just off it.
			spot    = $urandom_range(0, c3fm_pkg::WINDOW - 1);
			p[spot] = longint'(c3fm_pkg::WINDOW) * base - (total - p[spot]);
			if (kind >= 82)
				p[spot] += ($urandom_range(0, 1) != 0) ? longint'($urandom_range(1, 3)) :
				                                         -longint'($urandom_range(1, 3));
		end
		if (kind >= 92) begin
			// Indices around the edges of the representable range.
			case ($urandom_range(0, 3))
				0:       w.col = 16'd32767;
				1:       w.col = 16'd32768;
				2:       w.row = 16'd65535;
				default: begin
					w.col = 16'd0;
					w.row = 16'd0;
				end
			endcase
		end
		for (int i = 0; i < c3fm_pkg::WINDOW; i++)
			w.pix[i] = px(p[i]);
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Simple offsets in both directions, and the rounding of exact halves.
	task automatic test_offsets_and_rounding();
		window_t w;
		w = blank_window(16'd10, 16'd20);
		w.pix[c3fm_pkg::PIX_C] = px(100);
		send_window(w);
		// Sum 2^17, moment +1: offset is exactly one half LSB and rounds up.
		w = blank_window(16'd100, 16'd200);
		w.pix[c3fm_pkg::PIX_C]  = px(131071);
		w.pix[c3fm_pkg::PIX_MR] = px(1);
		send_window(w);
		// Same with moment -1: the half rounds away from zero, downward.
		w = blank_window(16'd100, 16'd200);
		w.pix[c3fm_pkg::PIX_C]  = px(131071);
		w.pix[c3fm_pkg::PIX_ML] = px(1);
		send_window(w);
		// Negative sum -2^17 with moment +1.
		w = blank_window(16'd100, 16'd200);
		w.pix[c3fm_pkg::PIX_C]  = px(-131073);
		w.pix[c3fm_pkg::PIX_MR] = px(1);
		send_window(w);
		w = blank_window(16'd7, 16'd7);
		w.pix[c3fm_pkg::PIX_UM] = px(3);
		w.pix[c3fm_pkg::PIX_DM] = px(1);
		send_window(w);
		w = blank_window(16'd50, 16'd60);
		w.pix[c3fm_pkg::PIX_UL] = px(5);
		send_window(w);
		w = blank_window(16'd50, 16'd60);
		w.pix[c3fm_pkg::PIX_DR] = px(-7);
		send_window(w);
	endtask

	task automatic test_pixel_extremes();
		window_t w;
		w = blank_window(16'd0, 16'd65535);
		for (int i = 0; i < c3fm_pkg::WINDOW; i++)
			w.pix[i] = PIX_MAX;
		send_window(w);
		w = blank_window(16'd65535, 16'd0);
		for (int i = 0; i < c3fm_pkg::WINDOW; i++)
			w.pix[i] = PIX_MIN;
		send_window(w);
		// Left column at full scale, right column at negative full scale: tiny sum.
		w = blank_window(16'd30000, 16'd30000);
		w.pix[c3fm_pkg::PIX_UL] = PIX_MAX;
		w.pix[c3fm_pkg::PIX_ML] = PIX_MAX;
		w.pix[c3fm_pkg::PIX_DL] = PIX_MAX;
		w.pix[c3fm_pkg::PIX_UR] = PIX_MIN;
		w.pix[c3fm_pkg::PIX_MR] = PIX_MIN;
		w.pix[c3fm_pkg::PIX_DR] = PIX_MIN;
		send_window(w);
		w = blank_window(16'd32767, 16'd32767);
		for (int i = 0; i < c3fm_pkg::WINDOW; i++)
			w.pix[i] = PIX_MIN;
		w.pix[c3fm_pkg::PIX_C] = PIX_MAX;
		send_window(w);
	endtask

	// Zero net sum must give zero positions and the no-counts status.
	task automatic test_no_counts();
		window_t w;
		w = blank_window(16'd65535, 16'd65535);
		send_window(w);
		w = blank_window(16'd32768, 16'd5);
		w.pix[c3fm_pkg::PIX_UL] = px(1000);
		w.pix[c3fm_pkg::PIX_DR] = px(-1000);
		send_window(w);
		w = blank_window(16'd1234, 16'd4321);
		w.pix[c3fm_pkg::PIX_UL] = PIX_MAX;
		w.pix[c3fm_pkg::PIX_UM] = PIX_MAX;
		w.pix[c3fm_pkg::PIX_UR] = PIX_MAX;
		w.pix[c3fm_pkg::PIX_DL] = px(-8388607);
		w.pix[c3fm_pkg::PIX_DM] = px(-8388607);
		w.pix[c3fm_pkg::PIX_DR] = px(-8388607);
		send_window(w);
	endtask

	// Clamping at both ends of the Q16.16 range, in each coordinate.
	task automatic test_saturation();
		window_t w;
		w = blank_window(16'd32768, 16'd0);
		w.pix[c3fm_pkg::PIX_C] = px(1);
		send_window(w);
		// Lands exactly on 2^31, one above the largest position.
		w = blank_window(16'd32767, 16'd100);
		w.pix[c3fm_pkg::PIX_MR] = px(1);
		send_window(w);
		// Sum 1 with large negative moments: both coordinates clamp low.
		w = blank_window(16'd0, 16'd0);
		w.pix[c3fm_pkg::PIX_ML] = px(4194304);
		w.pix[c3fm_pkg::PIX_DM] = px(4194304);
		w.pix[c3fm_pkg::PIX_C]  = px(-8388607);
		send_window(w);
		w = blank_window(16'd0, 16'd0);
		w.pix[c3fm_pkg::PIX_UM] = px(4194304);
		w.pix[c3fm_pkg::PIX_C]  = px(-4194303);
		send_window(w);
		w = blank_window(16'd65535, 16'd65535);
		w.pix[c3fm_pkg::PIX_C]  = px(500);
		w.pix[c3fm_pkg::PIX_MR] = px(20);
		send_window(w);
	endtask

	// Background at its extremes: a flat window at the background has no counts.
	task automatic test_background_extremes();
		window_t w;
		write_background(PIX_MAX);
		w = blank_window(16'd40, 16'd41);
		for (int i = 0; i < c3fm_pkg::WINDOW; i++)
			w.pix[i] = PIX_MAX;
		send_window(w);
		w = blank_window(16'd40, 16'd41);
		w.pix[c3fm_pkg::PIX_UR] = px(77);
		send_window(w);
		write_background(PIX_MIN);
		w = blank_window(16'd9, 16'd9);
		for (int i = 0; i < c3fm_pkg::WINDOW; i++)
			w.pix[i] = PIX_MIN;
		send_window(w);
		w.pix[c3fm_pkg::PIX_C]  = PIX_MAX;
		w.pix[c3fm_pkg::PIX_DL] = px(-8388000);
		send_window(w);
	endtask

	task automatic test_random_windows(input int count, input int send_pct, input int recv_pct,
	                                   input logic signed [c3fm_pkg::BG_BITS-1:0] level);
		write_background(level);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < count; n++)
			send_window(random_window());
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = '0;
		pix_in.valid          = 1'b0;
		pix_in.pix_up_left    = '0;
		pix_in.pix_up_mid     = '0;
		pix_in.pix_up_right   = '0;
		pix_in.pix_mid_left   = '0;
		pix_in.pix_center     = '0;
		pix_in.pix_mid_right  = '0;
		pix_in.pix_down_left  = '0;
		pix_in.pix_down_mid   = '0;
		pix_in.pix_down_right = '0;
		pix_in.col_index      = '0;
		pix_in.row_index      = '0;
		res_out.ready         = 1'b0;
		background_level      = '0;
		send_idle_pct         = 28;
		recv_idle_pct         = 78;
		mismatch_count        = 0;
		requests_sent         = 0;
		results_ok            = 0;
		results_no_counts     = 0;
		results_saturated     = 0;
		background_writes     = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed windows run first, against the reset background of zero until the background test writes its own.
		test_offsets_and_rounding();
		test_pixel_extremes();
		test_no_counts();
		test_saturation();
		test_background_extremes();

		// Random streams: slow receiver, then slow sender, then full rate.
		test_random_windows(250, 28, 78, c3fm_pkg::BG_BITS'($urandom));
		test_random_windows(250, 78, 28,
		                    c3fm_pkg::BG_BITS'($urandom_range(0, 2000)) - 24'sd1000);
		test_random_windows(250, 0, 0, '0);

		wait_for_results();
		// Any result beyond the last prediction would show up during this wait.
		repeat (PIPE_LATENCY + 16) @(posedge clk);

		$display("Sent %0d windows over %0d background settings and three idle patterns.",
		         requests_sent, background_writes + 1);
		$display("Results: %0d in range, %0d with no counts, %0d saturated.",
		         results_ok, results_no_counts, results_saturated);
		if (mismatch_count == 0 && pending_centroids.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timeout with %0d results still outstanding.", pending_centroids.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
